### design/axis_vector_rotation_top_assert.svh
// Assertion macros for the vector rotation block and its checker.
`ifndef AXIS_VECTOR_ROTATION_TOP_ASSERT_SVH
`define AXIS_VECTOR_ROTATION_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define VROT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define VROT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication that also holds during reset.
`define VROT_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) (ante) |-> (cons)) \
    else $error(msg);

`endif

### design/vrot_pkg.sv
// Shared constants, types and tables of the vector rotation block.
package vrot_pkg;

  // CORDIC depth, limited by the length of the arctangent table
  localparam int unsigned ROT_STAGES    = 16;
  localparam int unsigned ANG_TABLE_LEN = 24;
  localparam int unsigned CORDIC_N      =
      (ROT_STAGES < ANG_TABLE_LEN) ? ROT_STAGES : ANG_TABLE_LEN;

  // Field widths
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned VEC_W  = 32;
  localparam int unsigned ANG_W  = 16;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned IN_W   = 3 * VEC_W + ANG_W;
  localparam int unsigned OUT_W  = 3 * VEC_W;

  // Angle preprocessing: offset by one eighth turn, residual width
  localparam logic [ANG_W-1:0] ANG_OFFSET = 16'h2000;
  localparam int unsigned      RES_W      = ANG_W - 2;

  // Fixed-point constants
  localparam logic signed [VEC_W-1:0]  INV_GAIN_Q30 = 32'sh26DD3B6A;
  localparam int unsigned              FRAC_SHIFT   = 30;
  localparam logic signed [PROD_W-1:0] RND_HALF     = 64'sh0000_0000_2000_0000;
  localparam logic signed [PROD_W-1:0] SAT_MAX      = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [PROD_W-1:0] SAT_MIN      = 64'shFFFF_FFFF_8000_0000;
  localparam logic [VEC_W-1:0]         SAT_MAX_32   = 32'h7FFF_FFFF;
  localparam logic [VEC_W-1:0]         SAT_MIN_32   = 32'h8000_0000;

  // atan(2^-i) in units of 2^32 per turn
  localparam logic signed [VEC_W-1:0] ATAN_TURN32 [ANG_TABLE_LEN] = '{
    32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
    32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
    32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
    32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D,
    32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
    32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051
  };

  // Rotation axis codes; the fourth code means no rotation
  typedef enum logic [CMD_W-1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  // Quadrant of the angle after the eighth-turn offset
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  // Item context carried alongside the arithmetic
  typedef struct packed {
    logic [CMD_W-1:0]        axis;
    quad_e                   quad;
    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;
    logic signed [VEC_W-1:0] vz;
  } side_t;

endpackage

### design/axis_vector_rotation_top.sv
// Top level of the pipelined 3D vector rotation about a principal axis.
// Usage:
//   Input stream s_axis: tuser carries the axis (0 = X, 1 = Y, 2 = Z, 3 = none),
//   tdata carries vec_x, vec_y, vec_z (signed Q16.16) and a 16-bit binary angle.
//   Output stream m_axis: tdata carries the rotated out_x, out_y, out_z,
//   signed Q16.16, rounded to nearest and saturated.
//   Throughput: one item per cycle, every cycle the output side takes items.
//   Stages from the input to the port: one input stage, one stage per CORDIC
//   micro-rotation (16 CORDIC stages), then quadrant/operand select, multiply,
//   sum, and round/saturate into the output register.
//   Each stage holds a valid bit and loads when it is empty or its successor
//   moves, so bubbles close up while the receiver stalls and the input keeps
//   taking items until every stage is full. A stalled result holds steady.
//   Reset clears all valid bits; no result is pending after reset.
//   Axis code 3 returns the vector unchanged.
module axis_vector_rotation_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // vec_x [31:0], vec_y [63:32], vec_z [95:64], angle [111:96]
  input  logic [vrot_pkg::IN_W-1:0]   s_axis_tdata,
  // command [1:0]
  input  logic [vrot_pkg::CMD_W-1:0]  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // out_x [31:0], out_y [63:32], out_z [95:64]
  output logic [vrot_pkg::OUT_W-1:0]  m_axis_tdata
);
  import vrot_pkg::*;

  localparam int unsigned NC     = CORDIC_N;
  localparam int unsigned STG_N  = NC + 5;
  localparam int unsigned SEL_ST = NC + 1;
  localparam int unsigned PRD_ST = NC + 2;
  localparam int unsigned SUM_ST = NC + 3;
  localparam int unsigned OUT_ST = NC + 4;

  // Round a Q18.46 product sum to Q16.16 and clamp to 32 bits
  function automatic logic [VEC_W-1:0] round_sat(input logic signed [PROD_W-1:0] acc);
    logic signed [PROD_W-1:0] r;
    r = (acc + RND_HALF) >>> FRAC_SHIFT;
    if (r > SAT_MAX) begin
      return SAT_MAX_32;
    end else if (r < SAT_MIN) begin
      return SAT_MIN_32;
    end
    return r[VEC_W-1:0];
  endfunction

  logic [STG_N-1:0] vld_q;
  logic [STG_N-1:0] vld_d;
  logic [STG_N-1:0] en;

  // Stage handshake: a stage loads when empty or when its successor moves
  assign en[STG_N-1] = !vld_q[STG_N-1] || m_axis_tready;
  for (genvar k = 0; k < STG_N - 1; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end

  assign vld_d         = {vld_q[STG_N-2:0], s_axis_tvalid};
  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[STG_N-1];

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < STG_N; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  // Input stage: split the angle into quadrant and residual
  logic [ANG_W-1:0]        ang_shift;
  logic [RES_W-1:0]        ang_res;
  side_t                   in_side;
  logic signed [VEC_W-1:0] in_z;

  always_comb begin
    ang_shift    = s_axis_tdata[IN_W-1 -: ANG_W] + ANG_OFFSET;
    // residual minus one eighth turn, as a signed value
    ang_res      = {~ang_shift[RES_W-1], ang_shift[RES_W-2:0]};
    in_side.axis = s_axis_tuser;
    in_side.quad = quad_e'(ang_shift[ANG_W-1 -: 2]);
    in_side.vx   = s_axis_tdata[VEC_W-1:0];
    in_side.vy   = s_axis_tdata[2*VEC_W-1:VEC_W];
    in_side.vz   = s_axis_tdata[3*VEC_W-1:2*VEC_W];
    in_z         = {{(VEC_W-RES_W-16){ang_res[RES_W-1]}}, ang_res, 16'h0000};
  end

  logic signed [VEC_W-1:0] cx_q [0:NC];
  logic signed [VEC_W-1:0] cy_q [0:NC];
  logic signed [VEC_W-1:0] cz_q [0:NC];
  side_t                   side_q [0:NC];

  // Load the input stage
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      cx_q[0]   <= INV_GAIN_Q30;
      cy_q[0]   <= '0;
      cz_q[0]   <= in_z;
      side_q[0] <= in_side;
    end
  end

  // CORDIC micro-rotations, one per stage
  for (genvar i = 0; i < NC; i++) begin : g_cordic
    logic signed [VEC_W-1:0] x_d;
    logic signed [VEC_W-1:0] y_d;
    logic signed [VEC_W-1:0] z_d;

    always_comb begin
      if (!cz_q[i][VEC_W-1]) begin
        x_d = cx_q[i] - (cy_q[i] >>> i);
        y_d = cy_q[i] + (cx_q[i] >>> i);
        z_d = cz_q[i] - ATAN_TURN32[i];
      end else begin
        x_d = cx_q[i] + (cy_q[i] >>> i);
        y_d = cy_q[i] - (cx_q[i] >>> i);
        z_d = cz_q[i] + ATAN_TURN32[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[i+1]) begin
        cx_q[i+1]   <= x_d;
        cy_q[i+1]   <= y_d;
        cz_q[i+1]   <= z_d;
        side_q[i+1] <= side_q[i];
      end
    end
  end

  // Select stage: fold the quadrant into cosine/sine, pick the rotated pair
  logic signed [VEC_W-1:0] sel_c_d, sel_s_d, sel_a_d, sel_b_d;
  logic signed [VEC_W-1:0] sel_c_q, sel_s_q, sel_a_q, sel_b_q;
  side_t                   sel_side_q;

  always_comb begin
    case (side_q[NC].quad)
      QUAD_0: begin
        sel_c_d = cx_q[NC];
        sel_s_d = cy_q[NC];
      end
      QUAD_1: begin
        sel_c_d = -cy_q[NC];
        sel_s_d = cx_q[NC];
      end
      QUAD_2: begin
        sel_c_d = -cx_q[NC];
        sel_s_d = -cy_q[NC];
      end
      default: begin
        sel_c_d = cy_q[NC];
        sel_s_d = -cx_q[NC];
      end
    endcase
    case (side_q[NC].axis)
      AXIS_X: begin
        sel_a_d = side_q[NC].vy;
        sel_b_d = side_q[NC].vz;
      end
      AXIS_Y: begin
        sel_a_d = side_q[NC].vz;
        sel_b_d = side_q[NC].vx;
      end
      AXIS_Z: begin
        sel_a_d = side_q[NC].vx;
        sel_b_d = side_q[NC].vy;
      end
      default: begin
        sel_a_d = '0;
        sel_b_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[SEL_ST]) begin
      sel_c_q    <= sel_c_d;
      sel_s_q    <= sel_s_d;
      sel_a_q    <= sel_a_d;
      sel_b_q    <= sel_b_d;
      sel_side_q <= side_q[NC];
    end
  end

  // Multiply stage: four 32x32 signed products
  logic signed [PROD_W-1:0] prd_ac_q, prd_bs_q, prd_as_q, prd_bc_q;
  side_t                    prd_side_q;

  always_ff @(posedge clk_i) begin
    if (en[PRD_ST]) begin
      prd_ac_q   <= PROD_W'(sel_a_q) * PROD_W'(sel_c_q);
      prd_bs_q   <= PROD_W'(sel_b_q) * PROD_W'(sel_s_q);
      prd_as_q   <= PROD_W'(sel_a_q) * PROD_W'(sel_s_q);
      prd_bc_q   <= PROD_W'(sel_b_q) * PROD_W'(sel_c_q);
      prd_side_q <= sel_side_q;
    end
  end

  // Sum stage: a*C - b*S and a*S + b*C
  logic signed [PROD_W-1:0] sum_a_q, sum_b_q;
  side_t                    sum_side_q;

  always_ff @(posedge clk_i) begin
    if (en[SUM_ST]) begin
      sum_a_q    <= prd_ac_q - prd_bs_q;
      sum_b_q    <= prd_as_q + prd_bc_q;
      sum_side_q <= prd_side_q;
    end
  end

  // Output stage: round, saturate and place the rotated pair
  logic [VEC_W-1:0] rnd_a, rnd_b;
  logic [VEC_W-1:0] out_x_d, out_y_d, out_z_d;
  logic [VEC_W-1:0] out_x_q, out_y_q, out_z_q;

  always_comb begin
    rnd_a   = round_sat(sum_a_q);
    rnd_b   = round_sat(sum_b_q);
    out_x_d = sum_side_q.vx;
    out_y_d = sum_side_q.vy;
    out_z_d = sum_side_q.vz;
    case (sum_side_q.axis)
      AXIS_X: begin
        out_y_d = rnd_a;
        out_z_d = rnd_b;
      end
      AXIS_Y: begin
        out_z_d = rnd_a;
        out_x_d = rnd_b;
      end
      AXIS_Z: begin
        out_x_d = rnd_a;
        out_y_d = rnd_b;
      end
      default: begin
        out_x_d = sum_side_q.vx;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[OUT_ST]) begin
      out_x_q <= out_x_d;
      out_y_q <= out_y_d;
      out_z_q <= out_z_d;
    end
  end

  assign m_axis_tdata = {out_z_q, out_y_q, out_x_q};

endmodule

### design/vrot_checker.sv
// Port-level checker for the vector rotation block, bound to its top level.
`include "axis_vector_rotation_top_assert.svh"

module vrot_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [vrot_pkg::OUT_W-1:0] m_axis_tdata
);

  // A stalled result stays put until taken
  `VROT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // With the output free to move, every stage can move, so input is ready
  `VROT_ASSERT_NOW(a_ready_when_free, !m_axis_tvalid || m_axis_tready, s_axis_tready, "input not ready while output drains")

  // Reset empties the pipeline
  `VROT_ASSERT_ALWAYS(a_reset_empty, !rst_ni, !m_axis_tvalid, "result valid during reset")

  // An input offered while the output drains is taken at once
  `VROT_ASSERT_NOW(a_take_free, s_axis_tvalid && m_axis_tready, s_axis_tready, "input refused with output ready")

endmodule

bind axis_vector_rotation_top vrot_checker u_vrot_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
